// File: src/etot_pkg.sv
`timescale 1ns / 1ps

package etot_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP2,
    ST_CHECK,
    ST_WAIT_REST,
    ST_WAIT_ANS,
    ST_DONE
  } etot_state_t;

endpackage

// File: src/etot_div.sv
`timescale 1ns / 1ps

module etot_div #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [W:0]    partial;
  logic [W:0]    diff;
  logic          ge;

  // one restoring step per cycle while busy
  always_comb begin
    partial   = {rem_r, quo_r[W-1]};
    diff      = partial - {1'b0, den_r};
    ge        = (partial >= {1'b0, den_r});
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : partial[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: src/euler_totient_core.sv
`timescale 1ns / 1ps

// Euler totient by trial division. Each item runs alone: in_ready is high only while the
// core is idle, and a finished result waits in the output register so the next item can
// be taken meanwhile. Factor 2 is stripped one shift per cycle, then divisors 3, 5, 7 ...
// are tried while the divisor squared does not exceed the unfactored rest. All divisions
// go through one shared restoring divider; a large prime input is the slowest case, as
// every odd divisor up to its square root is tried. Zero gives totient 0 with out_invalid
// set; one gives 1.

module euler_totient_core #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_totient,
  output logic                  out_invalid
);

  import etot_pkg::*;

  localparam int W = VALUE_BITS;

  etot_state_t   state_r, state_nxt;
  logic [W-1:0]  ans_r, ans_nxt;
  logic [W-1:0]  rest_r, rest_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W+1:0]  sq_r, sq_nxt;
  logic          hit_r, hit_nxt;
  logic          final_r, final_nxt;
  logic          inval_r, inval_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_tot_r, out_tot_nxt;
  logic          out_inv_r, out_inv_nxt;

  logic          div_start;
  logic [W-1:0]  div_a;
  logic [W-1:0]  div_b;
  logic          div_done;
  logic [W-1:0]  div_q;
  logic [W-1:0]  div_rem;

  etot_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    ans_nxt       = ans_r;
    rest_nxt      = rest_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    hit_nxt       = hit_r;
    final_nxt     = final_r;
    inval_nxt     = inval_r;
    out_valid_nxt = out_valid_r;
    out_tot_nxt   = out_tot_r;
    out_inv_nxt   = out_inv_r;
    div_start     = 1'b0;
    div_a         = rest_r;
    div_b         = d_r;
    in_ready      = (state_r == ST_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ans_nxt   = in_value_in;
          rest_nxt  = in_value_in;
          d_nxt     = W'(3);
          sq_nxt    = (W+2)'(9);
          hit_nxt   = 1'b0;
          inval_nxt = 1'b0;
          if (in_value_in == '0) begin
            inval_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else if (!in_value_in[0]) begin
            ans_nxt   = in_value_in - (in_value_in >> 1);
            state_nxt = ST_STRIP2;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_STRIP2: begin
        if (!rest_r[0]) begin
          rest_nxt = rest_r >> 1;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq_r <= {2'b00, rest_r}) begin
          div_start = 1'b1;
          state_nxt = ST_WAIT_REST;
        end else if (rest_r > W'(1)) begin
          div_start = 1'b1;
          div_a     = ans_r;
          div_b     = rest_r;
          final_nxt = 1'b1;
          state_nxt = ST_WAIT_ANS;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WAIT_REST: begin
        if (div_done) begin
          if (div_rem == '0) begin
            rest_nxt  = div_q;
            div_start = 1'b1;
            if (!hit_r) begin
              hit_nxt   = 1'b1;
              div_a     = ans_r;
              final_nxt = 1'b0;
              state_nxt = ST_WAIT_ANS;
            end else begin
              div_a = div_q;
            end
          end else begin
            d_nxt     = d_r + W'(2);
            sq_nxt    = sq_r + {d_r, 2'b00} + (W+2)'(4);
            hit_nxt   = 1'b0;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_WAIT_ANS: begin
        if (div_done) begin
          ans_nxt = ans_r - div_q;
          if (final_r) begin
            state_nxt = ST_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_WAIT_REST;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_tot_nxt   = inval_r ? '0 : ans_r;
          out_inv_nxt   = inval_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ans_r     <= ans_nxt;
    rest_r    <= rest_nxt;
    d_r       <= d_nxt;
    sq_r      <= sq_nxt;
    hit_r     <= hit_nxt;
    final_r   <= final_nxt;
    inval_r   <= inval_nxt;
    out_tot_r <= out_tot_nxt;
    out_inv_r <= out_inv_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_totient = out_tot_r;
  assign out_invalid = out_inv_r;

endmodule

// File: src/etot_checker.sv
`timescale 1ns / 1ps

module etot_checker #(
  parameter int VALUE_BITS = 31
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] out_totient,
  input logic                  out_invalid
);

  // an invalid result always reports zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_totient == '0)
    else $error("invalid result with nonzero totient");

  // a valid input always has a nonzero totient
  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invalid |-> out_totient != '0)
    else $error("zero totient without invalid flag");

  // one item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_totient) && $stable(out_invalid))
    else $error("stalled result changed");

endmodule

bind euler_totient_core etot_checker #(.VALUE_BITS(VALUE_BITS)) u_etot_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_totient (out_totient),
  .out_invalid (out_invalid)
);
